// ----- rtl/core/cnghm_pkg.sv -----
// Package with types and constants shared by the node guard and heartbeat monitor.
`timescale 1ns / 1ps

package cnghm_pkg;

    // Node state codes, as reported on the result channel
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_DISC    = 3'd1;
    localparam logic [2:0] ST_STOPPED = 3'd2;
    localparam logic [2:0] ST_OPER    = 3'd3;
    localparam logic [2:0] ST_PREOP   = 3'd4;

    // Toggle bit memory
    localparam logic [1:0] TG_OFF     = 2'd0;
    localparam logic [1:0] TG_ON      = 2'd1;
    localparam logic [1:0] TG_UNKNOWN = 2'd2;

    // Frame error codes
    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_REQUEST     = 3'd1;
    localparam logic [2:0] ERR_EMPTY       = 3'd2;
    localparam logic [2:0] ERR_INVALID     = 3'd3;
    localparam logic [2:0] ERR_UNSOLICITED = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_PERIOD  = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT = 3'd2;
    localparam logic [2:0] CFG_REQ     = 3'd3;
    localparam logic [2:0] CFG_SPY     = 3'd4;
    localparam logic [2:0] CFG_NODE    = 3'd5;

    localparam logic MODE_GUARD = 1'b0;
    localparam logic OP_TICK    = 1'b0;

    // Requested state codes
    localparam logic [1:0] REQ_OPER    = 2'd0;
    localparam logic [1:0] REQ_STOPPED = 2'd1;
    localparam logic [1:0] REQ_PREOP   = 2'd2;

    // NMT command specifiers
    localparam logic [7:0] NMT_NONE  = 8'd0;
    localparam logic [7:0] NMT_START = 8'd1;
    localparam logic [7:0] NMT_STOP  = 8'd2;
    localparam logic [7:0] NMT_PREOP = 8'h80;

    // State values carried in bits 6..0 of a reply or heartbeat
    localparam logic [6:0] BYTE_STOPPED = 7'd4;
    localparam logic [6:0] BYTE_OPER    = 7'd5;
    localparam logic [6:0] BYTE_PREOP   = 7'h7F;

    localparam logic [2:0]  GRACE_LIMIT   = 3'd3;
    localparam logic [2:0]  GRACE_MAX     = 3'd7;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;
    localparam logic [15:0] PERIOD_RESET  = 16'd10000;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [6:0]  NODE_RESET    = 7'd1;
    localparam logic [7:0]  RAW_DISC      = 8'd1;

    typedef struct packed {
        logic       send_guard_request;
        logic       send_nmt;
        logic [7:0] nmt_command;
        logic [6:0] target_node;
        logic       state_report_valid;
        logic [2:0] reported_state;
        logic [7:0] raw_state_byte;
        logic       state_changed;
        logic [2:0] prior_state;
        logic       toggle_violation;
        logic       bootup_seen;
        logic [2:0] frame_error;
    } result_t;

endpackage

// ----- rtl/core/canopen_node_guard_heartbeat_monitor.sv -----
// Master-side node guarding and heartbeat supervision of one CANopen node.
//
// Usage: the s_ channel carries one item per 1 ms tick (s_op = 0) or per received
// node-management frame (s_op = 1). Every accepted item yields exactly one result
// on the m_ channel: guard request and NMT command strobes, an optional state
// report, toggle and boot-up flags and a frame error code.
// The cfg channel writes the six configuration registers; it is always ready and
// is meant to be used only while no item is in flight.
// The result of an item is registered and valid in the cycle after its acceptance.
// The block takes one item per cycle while the receiver does not stall; the
// decode, the 16-bit timer compares and the state update all sit between the
// input handshake and the result register.
// When the receiver stalls, the result register holds its item and s_ready drops
// until it is taken; s_ready is high whenever the result register is empty or
// being emptied in the same cycle.
// Reset (aresetn low, synchronous) clears the result valid flag and puts all
// timers, counters and configuration registers to their power-on values, with
// a guard request due on the first tick.
`timescale 1ns / 1ps

module canopen_node_guard_heartbeat_monitor (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic       s_remote_request,
    input  logic [3:0] s_data_length,
    input  logic [7:0] s_first_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_send_guard_request,
    output logic       m_send_nmt,
    output logic [7:0] m_nmt_command,
    output logic [6:0] m_target_node,
    output logic       m_state_report_valid,
    output logic [2:0] m_reported_state,
    output logic [7:0] m_raw_state_byte,
    output logic       m_state_changed,
    output logic [2:0] m_prior_state,
    output logic       m_toggle_violation,
    output logic       m_bootup_seen,
    output logic [2:0] m_frame_error
);

    // Configuration registers
    logic        mode_reg;
    logic [15:0] period_reg;
    logic [15:0] timeout_reg;
    logic [1:0]  req_state_reg;
    logic        spy_reg;
    logic [6:0]  node_id_reg;

    // Supervision state
    logic        awaiting_reply_reg, awaiting_reply_next;
    logic [15:0] guard_elapsed_reg, guard_elapsed_next;
    logic [15:0] window_elapsed_reg, window_elapsed_next;
    logic [2:0]  grace_count_reg, grace_count_next;
    logic [2:0]  current_state_reg, current_state_next;
    logic [2:0]  last_reported_reg, last_reported_next;
    logic [1:0]  last_toggle_reg, last_toggle_next;

    logic                  m_valid_reg;
    cnghm_pkg::result_t    result_reg;
    cnghm_pkg::result_t    result_next;
    logic                  s_accept;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        logic [15:0] guard_inc;
        logic [15:0] window_inc;
        logic [2:0]  grace_inc;
        logic        miss;
        logic        rep;
        logic [2:0]  rep_state;
        logic [7:0]  rep_raw;
        logic [2:0]  frame_state;
        logic        frame_ok;
        logic [1:0]  toggle_code;
        logic [2:0]  want_state;
        logic [7:0]  want_cmd;
        logic        want_ok;

        awaiting_reply_next = awaiting_reply_reg;
        guard_elapsed_next  = guard_elapsed_reg;
        window_elapsed_next = window_elapsed_reg;
        grace_count_next    = grace_count_reg;
        current_state_next  = current_state_reg;
        last_reported_next  = last_reported_reg;
        last_toggle_next    = last_toggle_reg;

        result_next             = '0;
        result_next.target_node = node_id_reg;

        miss      = 1'b0;
        rep       = 1'b0;
        rep_state = cnghm_pkg::ST_UNKNOWN;
        rep_raw   = 8'd0;

        guard_inc  = (guard_elapsed_reg == cnghm_pkg::TIMER_MAX) ?
                     guard_elapsed_reg : guard_elapsed_reg + 16'd1;
        window_inc = (window_elapsed_reg == cnghm_pkg::TIMER_MAX) ?
                     window_elapsed_reg : window_elapsed_reg + 16'd1;
        grace_inc  = (grace_count_reg == cnghm_pkg::GRACE_MAX) ?
                     grace_count_reg : grace_count_reg + 3'd1;
        toggle_code = s_first_byte[7] ? cnghm_pkg::TG_ON : cnghm_pkg::TG_OFF;

        case (s_first_byte[6:0])
            cnghm_pkg::BYTE_STOPPED: begin
                frame_state = cnghm_pkg::ST_STOPPED;
                frame_ok    = 1'b1;
            end
            cnghm_pkg::BYTE_OPER: begin
                frame_state = cnghm_pkg::ST_OPER;
                frame_ok    = 1'b1;
            end
            cnghm_pkg::BYTE_PREOP: begin
                frame_state = cnghm_pkg::ST_PREOP;
                frame_ok    = 1'b1;
            end
            default: begin
                frame_state = cnghm_pkg::ST_UNKNOWN;
                frame_ok    = 1'b0;
            end
        endcase

        case (req_state_reg)
            cnghm_pkg::REQ_OPER: begin
                want_state = cnghm_pkg::ST_OPER;
                want_cmd   = cnghm_pkg::NMT_START;
                want_ok    = 1'b1;
            end
            cnghm_pkg::REQ_STOPPED: begin
                want_state = cnghm_pkg::ST_STOPPED;
                want_cmd   = cnghm_pkg::NMT_STOP;
                want_ok    = 1'b1;
            end
            cnghm_pkg::REQ_PREOP: begin
                want_state = cnghm_pkg::ST_PREOP;
                want_cmd   = cnghm_pkg::NMT_PREOP;
                want_ok    = 1'b1;
            end
            default: begin
                want_state = cnghm_pkg::ST_UNKNOWN;
                want_cmd   = cnghm_pkg::NMT_NONE;
                want_ok    = 1'b0;
            end
        endcase

        if (s_op == cnghm_pkg::OP_TICK) begin
            if (mode_reg == cnghm_pkg::MODE_GUARD) begin
                guard_elapsed_next = guard_inc;
                // A timeout and a fresh request may fall on the same tick.
                if (awaiting_reply_reg && guard_inc >= timeout_reg) begin
                    awaiting_reply_next = 1'b0;
                    miss                = 1'b1;
                end
                if (!spy_reg && guard_inc >= period_reg) begin
                    result_next.send_guard_request = 1'b1;
                    awaiting_reply_next            = 1'b1;
                    guard_elapsed_next             = 16'd0;
                end
            end else begin
                window_elapsed_next = window_inc;
                if (!spy_reg && window_inc >= period_reg) begin
                    miss                = 1'b1;
                    window_elapsed_next = 16'd0;
                end
            end
            if (miss) begin
                grace_count_next = grace_inc;
                if (grace_inc > cnghm_pkg::GRACE_LIMIT) begin
                    current_state_next = cnghm_pkg::ST_DISC;
                    rep                = 1'b1;
                    rep_state          = cnghm_pkg::ST_DISC;
                    rep_raw            = cnghm_pkg::RAW_DISC;
                end
            end
        end else if (s_remote_request) begin
            // In spy mode a guard request seen on the bus starts the reply timer.
            if (spy_reg) begin
                awaiting_reply_next = 1'b1;
                guard_elapsed_next  = 16'd0;
            end else begin
                result_next.frame_error = cnghm_pkg::ERR_REQUEST;
            end
        end else if (s_data_length == 4'd0) begin
            result_next.frame_error = cnghm_pkg::ERR_EMPTY;
        end else if (s_first_byte == 8'd0) begin
            result_next.bootup_seen = 1'b1;
        end else if (!frame_ok) begin
            result_next.frame_error = cnghm_pkg::ERR_INVALID;
        end else if (mode_reg == cnghm_pkg::MODE_GUARD && !awaiting_reply_reg) begin
            result_next.frame_error = cnghm_pkg::ERR_UNSOLICITED;
        end else begin
            if (mode_reg == cnghm_pkg::MODE_GUARD) begin
                awaiting_reply_next = 1'b0;
            end else begin
                window_elapsed_next = 16'd0;
            end
            grace_count_next = 3'd0;
            if (current_state_reg != cnghm_pkg::ST_DISC &&
                last_toggle_reg != cnghm_pkg::TG_UNKNOWN &&
                last_toggle_reg == toggle_code) begin
                result_next.toggle_violation = 1'b1;
            end
            last_toggle_next   = toggle_code;
            current_state_next = frame_state;
            rep                = 1'b1;
            rep_state          = frame_state;
            rep_raw            = s_first_byte;
            if (want_ok && !spy_reg && frame_state != want_state) begin
                result_next.send_nmt    = 1'b1;
                result_next.nmt_command = want_cmd;
            end
        end

        if (rep) begin
            result_next.state_report_valid = 1'b1;
            result_next.reported_state     = rep_state;
            result_next.raw_state_byte     = rep_raw;
            if (rep_state != last_reported_reg) begin
                result_next.state_changed = 1'b1;
                result_next.prior_state   = last_reported_reg;
                last_reported_next        = rep_state;
                // Leaving the disconnected state forgets the toggle history.
                if (last_reported_reg == cnghm_pkg::ST_DISC) begin
                    last_toggle_next = cnghm_pkg::TG_UNKNOWN;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            period_reg    <= cnghm_pkg::PERIOD_RESET;
            timeout_reg   <= cnghm_pkg::TIMEOUT_RESET;
            req_state_reg <= cnghm_pkg::REQ_OPER;
            spy_reg       <= 1'b0;
            node_id_reg   <= cnghm_pkg::NODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cnghm_pkg::CFG_MODE:    mode_reg      <= cfg_data[0];
                cnghm_pkg::CFG_PERIOD:  period_reg    <= cfg_data;
                cnghm_pkg::CFG_TIMEOUT: timeout_reg   <= cfg_data;
                cnghm_pkg::CFG_REQ:     req_state_reg <= cfg_data[1:0];
                cnghm_pkg::CFG_SPY:     spy_reg       <= cfg_data[0];
                cnghm_pkg::CFG_NODE:    node_id_reg   <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reply_reg <= 1'b0;
            guard_elapsed_reg  <= cnghm_pkg::TIMER_MAX;
            window_elapsed_reg <= 16'd0;
            grace_count_reg    <= 3'd0;
            current_state_reg  <= cnghm_pkg::ST_UNKNOWN;
            last_reported_reg  <= cnghm_pkg::ST_UNKNOWN;
            last_toggle_reg    <= cnghm_pkg::TG_UNKNOWN;
        end else if (s_accept) begin
            awaiting_reply_reg <= awaiting_reply_next;
            guard_elapsed_reg  <= guard_elapsed_next;
            window_elapsed_reg <= window_elapsed_next;
            grace_count_reg    <= grace_count_next;
            current_state_reg  <= current_state_next;
            last_reported_reg  <= last_reported_next;
            last_toggle_reg    <= last_toggle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_send_guard_request = result_reg.send_guard_request;
    assign m_send_nmt           = result_reg.send_nmt;
    assign m_nmt_command        = result_reg.nmt_command;
    assign m_target_node        = result_reg.target_node;
    assign m_state_report_valid = result_reg.state_report_valid;
    assign m_reported_state     = result_reg.reported_state;
    assign m_raw_state_byte     = result_reg.raw_state_byte;
    assign m_state_changed      = result_reg.state_changed;
    assign m_prior_state        = result_reg.prior_state;
    assign m_toggle_violation   = result_reg.toggle_violation;
    assign m_bootup_seen        = result_reg.bootup_seen;
    assign m_frame_error        = result_reg.frame_error;

endmodule

// ----- rtl/core/cnghm_checker.sv -----
// Port-level checker for the node guard and heartbeat monitor, with its bind.
`timescale 1ns / 1ps

module cnghm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_send_nmt,
    input logic       m_state_report_valid,
    input logic [2:0] m_frame_error,
    input logic [2:0] m_reported_state,
    input logic [7:0] m_raw_state_byte
);

    // An accepted item always shows up as a result on the next cycle.
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted item produced no result");

    // A held result blocks new items.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while result stalled");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reported_state) &&
            $stable(m_raw_state_byte) && $stable(m_frame_error))
        else $error("stalled result changed");

    // A corrective NMT command only comes with a good state report in the same result.
    a_nmt_needs_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_send_nmt |-> m_state_report_valid &&
            m_frame_error == cnghm_pkg::ERR_NONE &&
            m_reported_state != cnghm_pkg::ST_DISC)
        else $error("NMT command without a valid state report");

endmodule

bind canopen_node_guard_heartbeat_monitor cnghm_checker u_cnghm_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_send_nmt           (m_send_nmt),
    .m_state_report_valid (m_state_report_valid),
    .m_frame_error        (m_frame_error),
    .m_reported_state     (m_reported_state),
    .m_raw_state_byte     (m_raw_state_byte)
);
